// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the smoothing filter.
// Checks compile away when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Assert a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Assert that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/rgbsf_pkg.sv =====
// Shared constants and types of the RGB 3x3 smoothing filter.
// Used by the line buffer, the kernel and the top level; no dependencies.
package rgbsf_pkg;

    localparam int MAX_SIZE     = 512;
    localparam int MIN_SIZE     = 3;
    localparam int CHANNEL_BITS = 16;
    localparam int OUT_BITS     = CHANNEL_BITS + 2;
    localparam int SIZE_BITS    = 10;
    localparam int POS_BITS     = $clog2(MAX_SIZE);
    localparam int ADDR_BITS    = $clog2(MAX_SIZE);

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(64);

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [OUT_BITS-1:0]     out_chan_t;
    typedef logic [POS_BITS-1:0]     pos_t;
    typedef logic [ADDR_BITS-1:0]    addr_t;

    // red in the lowest bits
    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
    } pixel_t;

    typedef struct packed {
        out_chan_t blue;
        out_chan_t green;
        out_chan_t red;
    } out_pixel_t;

    // one line buffer entry: rows r-2 and r-1 of a column
    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } lb_entry_t;

    typedef struct packed {
        logic  rd_en;
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
    } lb_ctl_t;

endpackage

// ===== hw/rtl/rgbsf_linebuf.sv =====
// Two line buffers of the smoothing filter held in one memory, one entry per column.
// Registered read with write-to-read forwarding. Depends on rgbsf_pkg.
module rgbsf_linebuf (
    input  logic                aclk,
    input  rgbsf_pkg::lb_ctl_t  ctl,
    input  rgbsf_pkg::lb_entry_t wr_data,
    output rgbsf_pkg::lb_entry_t rd_data
);

    rgbsf_pkg::lb_entry_t mem [rgbsf_pkg::MAX_SIZE];
    rgbsf_pkg::lb_entry_t rd_reg;
    rgbsf_pkg::lb_entry_t byp_data_reg;
    logic                 byp_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= wr_data;
        end
    end

    // the memory read returns old data on a collision, so forward the write word
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_reg       <= mem[ctl.rd_addr];
            byp_reg      <= ctl.wr_en && (ctl.wr_addr == ctl.rd_addr);
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_reg;

endmodule

// ===== hw/rtl/rgbsf_kernel.sv =====
// Weighted 3x3 sum for the three channels: centre 1, edges 1/4, corners 1/8.
// Pure combinational datapath. Depends on rgbsf_pkg.
module rgbsf_kernel (
    input  rgbsf_pkg::pixel_t     w0_top,
    input  rgbsf_pkg::pixel_t     w0_mid,
    input  rgbsf_pkg::pixel_t     w0_cur,
    input  rgbsf_pkg::pixel_t     w1_top,
    input  rgbsf_pkg::pixel_t     w1_mid,
    input  rgbsf_pkg::pixel_t     w1_cur,
    input  rgbsf_pkg::pixel_t     top,
    input  rgbsf_pkg::pixel_t     mid,
    input  rgbsf_pkg::pixel_t     cur,
    output rgbsf_pkg::out_pixel_t result
);

    // truncate every shifted term before the sum
    function automatic rgbsf_pkg::out_chan_t smooth(
        input rgbsf_pkg::chan_t ctr,
        input rgbsf_pkg::chan_t e0,
        input rgbsf_pkg::chan_t e1,
        input rgbsf_pkg::chan_t e2,
        input rgbsf_pkg::chan_t e3,
        input rgbsf_pkg::chan_t k0,
        input rgbsf_pkg::chan_t k1,
        input rgbsf_pkg::chan_t k2,
        input rgbsf_pkg::chan_t k3
    );
        rgbsf_pkg::out_chan_t sum;
        sum = rgbsf_pkg::out_chan_t'(ctr)
            + rgbsf_pkg::out_chan_t'(e0 >> 2) + rgbsf_pkg::out_chan_t'(e1 >> 2)
            + rgbsf_pkg::out_chan_t'(e2 >> 2) + rgbsf_pkg::out_chan_t'(e3 >> 2)
            + rgbsf_pkg::out_chan_t'(k0 >> 3) + rgbsf_pkg::out_chan_t'(k1 >> 3)
            + rgbsf_pkg::out_chan_t'(k2 >> 3) + rgbsf_pkg::out_chan_t'(k3 >> 3);
        return sum;
    endfunction

    assign result.red   = smooth(w0_mid.red, w0_top.red, w0_cur.red, w1_mid.red, mid.red,
                                 w1_top.red, w1_cur.red, top.red, cur.red);
    assign result.green = smooth(w0_mid.green, w0_top.green, w0_cur.green, w1_mid.green,
                                 mid.green, w1_top.green, w1_cur.green, top.green,
                                 cur.green);
    assign result.blue  = smooth(w0_mid.blue, w0_top.blue, w0_cur.blue, w1_mid.blue,
                                 mid.blue, w1_top.blue, w1_cur.blue, top.blue, cur.blue);

endmodule

// ===== hw/rtl/rgb_3x3_smoothing_filter.sv =====
// Top level of the RGB 3x3 smoothing filter: position counters, window and handshake.
// Depends on rgbsf_pkg, rgbsf_linebuf, rgbsf_kernel and assert_macros.svh.
//
//   channel | direction | payload
//   s_axis  | in        | tdata = red, green, blue; tuser = frame_start
//   m_axis  | out       | tdata = red, green, blue, row, col; tlast = frame_last
//   cfg     | in        | cfg_wr_data = image_size
//
// One pixel is accepted per cycle while the input side is ready; the pixel that
// completes a window passes the input register (with the line buffer read), then the result register.
// One line buffer read and one write per cycle, with the kernel sum fitting between
// the input and result registers, set that rate.
// Reset (aresetn low, synchronous) clears counters, window and valid flags; no
// clearing pass. The input side keeps accepting while a result waits, until the
// input register holds a result-producing word that cannot move on.
`include "assert_macros.svh"

module rgb_3x3_smoothing_filter (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,     // image_size

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,    // red[15:0], green[31:16], blue[47:32]
    input  logic        s_axis_tuser,    // frame_start

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,    // red[17:0], green[35:18], blue[53:36],
                                         // out_row[62:54], out_col[71:63]
    output logic        m_axis_tlast     // frame_last
);

    localparam int SB = rgbsf_pkg::SIZE_BITS;

    logic [SB-1:0]       size_reg;
    logic [SB-1:0]       eff_size;
    rgbsf_pkg::pos_t     row_reg, col_reg, row_next, col_next;
    rgbsf_pkg::pos_t     row_a, col_a;
    logic [SB-1:0]       row_w, col_w, col_inc, row_inc;
    logic                emit_a, last_a, accept;

    logic                s1_valid_reg, s1_emit_reg, s1_last_reg, s1_go, out_free;
    rgbsf_pkg::pixel_t   s1_pix_reg;
    rgbsf_pkg::pos_t     s1_row_reg, s1_col_reg;

    rgbsf_pkg::pixel_t   w0_top_reg, w0_mid_reg, w0_cur_reg;
    rgbsf_pkg::pixel_t   w1_top_reg, w1_mid_reg, w1_cur_reg;

    rgbsf_pkg::lb_ctl_t    lb_ctl;
    rgbsf_pkg::lb_entry_t  lb_wr, lb_rd;
    rgbsf_pkg::out_pixel_t kern_out;

    logic                  m_valid_reg, m_last_reg;
    rgbsf_pkg::out_pixel_t m_pix_reg;
    rgbsf_pkg::pos_t       m_row_reg, m_col_reg;

    // clamp the configured size
    always_comb begin
        priority if (size_reg < SB'(rgbsf_pkg::MIN_SIZE)) begin
            eff_size = SB'(rgbsf_pkg::MIN_SIZE);
        end else if (size_reg > SB'(rgbsf_pkg::MAX_SIZE)) begin
            eff_size = SB'(rgbsf_pkg::MAX_SIZE);
        end else begin
            eff_size = size_reg;
        end
    end

    // position of the arriving pixel and of the one after it
    always_comb begin
        col_w = s_axis_tuser ? '0 : {1'b0, col_reg};
        row_w = s_axis_tuser ? '0 : {1'b0, row_reg};
        if (col_w >= eff_size) begin
            col_w = '0;
            row_w = row_w + SB'(1);
        end
        if (row_w >= eff_size) begin
            row_w = '0;
        end
        row_a = row_w[rgbsf_pkg::POS_BITS-1:0];
        col_a = col_w[rgbsf_pkg::POS_BITS-1:0];

        col_inc = {1'b0, col_a} + SB'(1);
        row_inc = {1'b0, row_a} + SB'(1);
        if (col_inc >= eff_size) begin
            col_next = '0;
            row_next = (row_inc >= eff_size) ? '0 : row_inc[rgbsf_pkg::POS_BITS-1:0];
        end else begin
            col_next = col_inc[rgbsf_pkg::POS_BITS-1:0];
            row_next = row_a;
        end

        emit_a = (row_a >= rgbsf_pkg::pos_t'(2)) && (col_a >= rgbsf_pkg::pos_t'(2));
        last_a = ({1'b0, row_a} == eff_size - SB'(1)) && ({1'b0, col_a} == eff_size - SB'(1));
    end

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s1_go         = s1_valid_reg && (!s1_emit_reg || out_free);
    assign s_axis_tready = !s1_valid_reg || s1_go;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign lb_ctl.rd_en   = accept;
    assign lb_ctl.rd_addr = col_a;
    assign lb_ctl.wr_en   = s1_go;
    assign lb_ctl.wr_addr = s1_col_reg;
    assign lb_wr.upper    = lb_rd.middle;
    assign lb_wr.middle   = s1_pix_reg;

    rgbsf_linebuf u_linebuf (
        .aclk    (aclk),
        .ctl     (lb_ctl),
        .wr_data (lb_wr),
        .rd_data (lb_rd)
    );

    rgbsf_kernel u_kernel (
        .w0_top (w0_top_reg),
        .w0_mid (w0_mid_reg),
        .w0_cur (w0_cur_reg),
        .w1_top (w1_top_reg),
        .w1_mid (w1_mid_reg),
        .w1_cur (w1_cur_reg),
        .top    (lb_rd.upper),
        .mid    (lb_rd.middle),
        .cur    (s1_pix_reg),
        .result (kern_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= rgbsf_pkg::SIZE_RESET;
        end else if (cfg_wr_en) begin
            size_reg <= cfg_wr_data;
        end
    end

    // input register and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                row_reg      <= row_next;
                col_reg      <= col_next;
                s1_valid_reg <= 1'b1;
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg  <= rgbsf_pkg::pixel_t'(s_axis_tdata);
            s1_row_reg  <= row_a;
            s1_col_reg  <= col_a;
            s1_emit_reg <= emit_a;
            s1_last_reg <= last_a;
        end
    end

    // advance the window as the word leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w0_top_reg <= '0;
            w0_mid_reg <= '0;
            w0_cur_reg <= '0;
            w1_top_reg <= '0;
            w1_mid_reg <= '0;
            w1_cur_reg <= '0;
        end else if (s1_go) begin
            w1_top_reg <= w0_top_reg;
            w1_mid_reg <= w0_mid_reg;
            w1_cur_reg <= w0_cur_reg;
            w0_top_reg <= lb_rd.upper;
            w0_mid_reg <= lb_rd.middle;
            w0_cur_reg <= s1_pix_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_go && s1_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go && s1_emit_reg) begin
            m_pix_reg  <= kern_out;
            m_row_reg  <= s1_row_reg - rgbsf_pkg::pos_t'(1);
            m_col_reg  <= s1_col_reg - rgbsf_pkg::pos_t'(1);
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_col_reg, m_row_reg, m_pix_reg};
    assign m_axis_tlast  = m_last_reg;

    `ASSERT_ALWAYS(a_stall_cause, aclk, aresetn, !s_axis_tready |-> (s1_valid_reg && s1_emit_reg && m_valid_reg), "input stalled without a blocked result")
    `ASSERT_NEXT(a_hold_word, aclk, aresetn, s1_valid_reg && !s1_go, s1_valid_reg && $stable(s1_col_reg), "stalled input word lost")
    `ASSERT_ALWAYS(a_interior, aclk, aresetn, m_valid_reg |-> (m_row_reg >= rgbsf_pkg::pos_t'(1) && m_col_reg >= rgbsf_pkg::pos_t'(1)), "result on a border pixel")

endmodule
